// ----- hdl/flac_frame_header_checker_core_defines.svh -----
// assertion macros for the flac frame header checker
// used by hdl/flac_frame_header_checker_core.sv, needs clk and rst_n in scope
`ifndef FLAC_FRAME_HEADER_CHECKER_CORE_DEFINES_SVH
`define FLAC_FRAME_HEADER_CHECKER_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define FFHC_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define FFHC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/ffhc_pkg.sv -----
// types, codes and helper functions of the flac frame header checker
// no dependencies; imported by hdl/flac_frame_header_checker_core.sv
package ffhc_pkg;

    localparam int MAX_HEADER_BYTES = 16;
    localparam int BPOS_W = $clog2(MAX_HEADER_BYTES + 1);

    // verdict codes
    localparam logic [3:0] ST_VALID     = 4'd0;
    localparam logic [3:0] ST_BAD_SYNC  = 4'd1;
    localparam logic [3:0] ST_RATE_RSVD = 4'd2;
    localparam logic [3:0] ST_CHAN_RSVD = 4'd3;
    localparam logic [3:0] ST_BPS_RSVD  = 4'd4;
    localparam logic [3:0] ST_BAD_UTF8  = 4'd5;
    localparam logic [3:0] ST_TRUNC     = 4'd6;
    localparam logic [3:0] ST_CRC       = 4'd7;
    localparam logic [3:0] ST_ZERO_SIZE = 4'd8;

    // fixed header byte positions
    localparam logic [BPOS_W-1:0] POS_SYNC_HI = BPOS_W'(0);
    localparam logic [BPOS_W-1:0] POS_SYNC_LO = BPOS_W'(1);
    localparam logic [BPOS_W-1:0] POS_SIZE_RATE = BPOS_W'(2);
    localparam logic [BPOS_W-1:0] POS_CHAN_BPS = BPOS_W'(3);
    localparam logic [BPOS_W-1:0] POS_NUMBER = BPOS_W'(4);

    // special code values
    localparam logic [3:0] SIZE_EXPL8   = 4'd6;
    localparam logic [3:0] SIZE_EXPL16  = 4'd7;
    localparam logic [3:0] RATE_EXPL8   = 4'd12;
    localparam logic [3:0] RATE_EXPL16A = 4'd13;
    localparam logic [3:0] RATE_EXPL16B = 4'd14;
    localparam logic [3:0] RATE_RSVD    = 4'd15;
    localparam logic [3:0] CHAN_MAX     = 4'd10;
    localparam logic [2:0] BPS_RSVD     = 3'd3;
    localparam logic [7:0] SYNC_HI      = 8'hFF;
    localparam logic [7:0] SYNC_LO_FIX  = 8'hF8;
    localparam logic [7:0] SYNC_LO_VAR  = 8'hF9;
    localparam logic [7:0] CRC_POLY     = 8'h07;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first;
        logic       last_available;
    } ffhc_in_t;

    typedef struct packed {
        logic [3:0]  status;
        logic [16:0] block_size;
        logic [4:0]  header_length;
        logic [35:0] frame_or_sample_number;
        logic        variable_blocking;
        logic [3:0]  rate_code;
        logic [3:0]  channel_code;
        logic [2:0]  depth_code;
    } ffhc_out_t;

    // block size from the 4 bit size code, 0 for reserved and explicit codes
    function automatic logic [16:0] size_table(input logic [3:0] code);
        logic [16:0] v;
        case (code)
            4'd1:    v = 17'd192;
            4'd2:    v = 17'd576;
            4'd3:    v = 17'd1152;
            4'd4:    v = 17'd2304;
            4'd5:    v = 17'd4608;
            4'd8:    v = 17'd256;
            4'd9:    v = 17'd512;
            4'd10:   v = 17'd1024;
            4'd11:   v = 17'd2048;
            4'd12:   v = 17'd4096;
            4'd13:   v = 17'd8192;
            4'd14:   v = 17'd16384;
            4'd15:   v = 17'd32768;
            default: v = 17'd0;
        endcase
        return v;
    endfunction

    // crc-8, msb first, one byte per call
    function automatic logic [7:0] crc8_next(input logic [7:0] c, input logic [7:0] b);
        logic [7:0] v;
        v = c ^ b;
        for (int i = 0; i < 8; i++) begin
            v = v[7] ? ({v[6:0], 1'b0} ^ CRC_POLY) : {v[6:0], 1'b0};
        end
        return v;
    endfunction

    // count of leading one bits, 0 to 8
    function automatic logic [3:0] lead_ones(input logic [7:0] b);
        logic [3:0] n;
        logic       run;
        n = 4'd0;
        run = 1'b1;
        for (int i = 7; i >= 0; i--) begin
            run = run & b[i];
            n = n + {3'd0, run};
        end
        return n;
    endfunction

endpackage

// ----- hdl/flac_frame_header_checker_core.sv -----
// flac frame header checker: byte-wise header parse, code checks and crc-8
// depends on hdl/ffhc_pkg.sv and hdl/flac_frame_header_checker_core_defines.svh
//
// usage
//   hdr_byte channel: one header byte per transfer with first and last_available
//   flags; first opens a new candidate (dropping any open one), bytes with first
//   low while no candidate is open are taken and ignored
//   verdict channel: at most one transfer per candidate carrying status and the
//   decoded fields, issued at the crc byte, at the first byte that shows an error,
//   or at a byte flagged last_available before the header is complete
// timing
//   a byte lands in the input register on the edge of its transfer; the parse
//   then loads the verdict register, which offers the verdict, once the pipe
//   advances; one byte per cycle is sustained unless a held verdict stalls it;
//   the per-byte crc update, code checks and field capture all sit between the
//   input register and the verdict register
// reset
//   rst_n clears both valid flags and the parse state; the first candidate
//   needs a byte flagged first
// backpressure
//   while a verdict waits with verdict_ready low, the input register holds
//   its byte and hdr_byte_ready stays low once that register is full
`include "flac_frame_header_checker_core_defines.svh"

module flac_frame_header_checker_core
    import ffhc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      hdr_byte_valid,
    output logic      hdr_byte_ready,
    input  ffhc_in_t  hdr_byte,
    output logic      verdict_valid,
    input  logic      verdict_ready,
    output ffhc_out_t verdict
);

    // input register
    logic     in_valid_reg;
    ffhc_in_t in_item_reg;

    // verdict register
    logic      out_valid_reg;
    ffhc_out_t out_item_reg;
    ffhc_out_t out_item_next;
    logic      res_valid;

    // parse state
    logic [BPOS_W-1:0] pos_reg, pos_next;
    logic              active_reg, active_next;
    logic [7:0]        crc_reg, crc_next;
    logic [3:0]        size_code_reg, size_code_next;
    logic [3:0]        rate_code_reg, rate_code_next;
    logic [3:0]        chan_code_reg, chan_code_next;
    logic [2:0]        depth_code_reg, depth_code_next;
    logic              variable_reg, variable_next;
    logic [35:0]       number_reg, number_next;
    logic [2:0]        utf8_left_reg, utf8_left_next;
    logic [2:0]        opt_left_reg, opt_left_next;
    logic [15:0]       size_acc_reg, size_acc_next;

    logic advance;
    logic fire;
    logic in_xfer;

    // state after the optional restart on first
    logic [BPOS_W-1:0] pos_e;
    logic              active_e;
    logic [7:0]        crc_e;
    logic [3:0]        size_code_e;
    logic [3:0]        rate_code_e;
    logic [35:0]       number_e;
    logic [2:0]        utf8_left_e;
    logic [2:0]        opt_left_e;
    logic [15:0]       size_acc_e;

    logic [7:0]  b;
    logic [3:0]  n_lead;
    logic [7:0]  num_mask;
    logic [1:0]  size_x;
    logic [1:0]  rate_x;
    logic        found;
    logic [3:0]  st;
    logic        crc_byte;
    logic [16:0] bsize;

    // the pipe moves whenever the verdict register is free or being drained
    assign advance        = !out_valid_reg || verdict_ready;
    assign fire           = in_valid_reg && advance;
    assign hdr_byte_ready = !in_valid_reg || advance;
    assign in_xfer        = hdr_byte_valid && hdr_byte_ready;
    assign verdict_valid  = out_valid_reg;
    assign verdict        = out_item_reg;

    always_comb
    begin
        b = in_item_reg.data_byte;

        // restart clears everything and opens a candidate
        if (in_item_reg.first)
        begin
            pos_e       = '0;
            active_e    = 1'b1;
            crc_e       = '0;
            size_code_e = '0;
            rate_code_e = '0;
            number_e    = '0;
            utf8_left_e = '0;
            opt_left_e  = '0;
            size_acc_e  = '0;
            chan_code_next  = '0;
            depth_code_next = '0;
            variable_next   = 1'b0;
        end
        else
        begin
            pos_e       = pos_reg;
            active_e    = active_reg;
            crc_e       = crc_reg;
            size_code_e = size_code_reg;
            rate_code_e = rate_code_reg;
            number_e    = number_reg;
            utf8_left_e = utf8_left_reg;
            opt_left_e  = opt_left_reg;
            size_acc_e  = size_acc_reg;
            chan_code_next  = chan_code_reg;
            depth_code_next = depth_code_reg;
            variable_next   = variable_reg;
        end

        pos_next       = pos_e;
        active_next    = active_e;
        crc_next       = crc_e;
        size_code_next = size_code_e;
        rate_code_next = rate_code_e;
        number_next    = number_e;
        utf8_left_next = utf8_left_e;
        opt_left_next  = opt_left_e;
        size_acc_next  = size_acc_e;

        // optional bytes after the number, from codes already captured
        size_x = (size_code_e == SIZE_EXPL8) ? 2'd1 :
                 (size_code_e == SIZE_EXPL16) ? 2'd2 : 2'd0;
        rate_x = (rate_code_e == RATE_EXPL8) ? 2'd1 :
                 ((rate_code_e == RATE_EXPL16A) || (rate_code_e == RATE_EXPL16B)) ? 2'd2 : 2'd0;

        n_lead   = lead_ones(b);
        num_mask = 8'hFF >> (n_lead + 4'd1);

        found    = 1'b0;
        st       = ST_VALID;
        crc_byte = 1'b0;
        bsize    = '0;
        res_valid = 1'b0;

        if (active_e)
        begin
            if (pos_e == POS_SYNC_HI)
            begin
                if (b != SYNC_HI)
                begin
                    found = 1'b1;
                    st    = ST_BAD_SYNC;
                end
            end
            else if (pos_e == POS_SYNC_LO)
            begin
                if ((b != SYNC_LO_FIX) && (b != SYNC_LO_VAR))
                begin
                    found = 1'b1;
                    st    = ST_BAD_SYNC;
                end
                else
                begin
                    variable_next = b[0];
                end
            end
            else if (pos_e == POS_SIZE_RATE)
            begin
                size_code_next = b[7:4];
                rate_code_next = b[3:0];
                if (b[3:0] == RATE_RSVD)
                begin
                    found = 1'b1;
                    st    = ST_RATE_RSVD;
                end
            end
            else if (pos_e == POS_CHAN_BPS)
            begin
                chan_code_next  = b[7:4];
                depth_code_next = b[3:1];
                if (b[7:4] > CHAN_MAX)
                begin
                    found = 1'b1;
                    st    = ST_CHAN_RSVD;
                end
                else if (b[3:1] == BPS_RSVD)
                begin
                    found = 1'b1;
                    st    = ST_BPS_RSVD;
                end
            end
            else if (pos_e == POS_NUMBER)
            begin
                // lead byte of the utf-8 style number
                if (n_lead == 4'd0)
                begin
                    number_next    = {28'd0, b};
                    utf8_left_next = 3'd0;
                end
                else if ((n_lead == 4'd1) || (n_lead == 4'd8))
                begin
                    found = 1'b1;
                    st    = ST_BAD_UTF8;
                end
                else
                begin
                    number_next    = (n_lead == 4'd7) ? 36'd0 : {28'd0, b & num_mask};
                    utf8_left_next = 3'(n_lead - 4'd1);
                end
                opt_left_next = {1'b0, size_x} + {1'b0, rate_x};
            end
            else if (utf8_left_e != 3'd0)
            begin
                if (b[7:6] != 2'b10)
                begin
                    found = 1'b1;
                    st    = ST_BAD_UTF8;
                end
                else
                begin
                    number_next    = {number_e[29:0], b[5:0]};
                    utf8_left_next = utf8_left_e - 3'd1;
                end
            end
            else if (opt_left_e != 3'd0)
            begin
                // size bytes come before rate bytes
                if (opt_left_e > {1'b0, rate_x})
                begin
                    size_acc_next = {size_acc_e[7:0], b};
                end
                opt_left_next = opt_left_e - 3'd1;
            end
            else
            begin
                crc_byte = 1'b1;
                found    = 1'b1;
                if ((size_code_e == SIZE_EXPL8) || (size_code_e == SIZE_EXPL16))
                begin
                    bsize = {1'b0, size_acc_e} + 17'd1;
                end
                else
                begin
                    bsize = size_table(size_code_e);
                end
                if (b != crc_e)
                begin
                    st = ST_CRC;
                end
                else if (bsize == 17'd0)
                begin
                    st = ST_ZERO_SIZE;
                end
                else
                begin
                    st = ST_VALID;
                end
            end

            if (!found)
            begin
                crc_next = crc8_next(crc_e, b);
                if (pos_e < BPOS_W'(MAX_HEADER_BYTES))
                begin
                    pos_next = pos_e + BPOS_W'(1);
                end
                if (in_item_reg.last_available)
                begin
                    found = 1'b1;
                    st    = ST_TRUNC;
                end
            end

            if (found)
            begin
                res_valid   = 1'b1;
                active_next = 1'b0;
            end
        end

        out_item_next.status                 = st;
        out_item_next.block_size             = crc_byte ? bsize : 17'd0;
        out_item_next.header_length          = 5'(pos_e) + 5'd1;
        out_item_next.frame_or_sample_number = crc_byte ? number_e : 36'd0;
        out_item_next.variable_blocking      = variable_next;
        out_item_next.rate_code              = rate_code_next;
        out_item_next.channel_code           = chan_code_next;
        out_item_next.depth_code             = depth_code_next;
    end

    // control and parse state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            pos_reg        <= '0;
            active_reg     <= 1'b0;
            crc_reg        <= '0;
            size_code_reg  <= '0;
            rate_code_reg  <= '0;
            chan_code_reg  <= '0;
            depth_code_reg <= '0;
            variable_reg   <= 1'b0;
            number_reg     <= '0;
            utf8_left_reg  <= '0;
            opt_left_reg   <= '0;
            size_acc_reg   <= '0;
        end
        else
        begin
            if (in_xfer)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= fire && res_valid;
            end

            if (fire)
            begin
                pos_reg        <= pos_next;
                active_reg     <= active_next;
                crc_reg        <= crc_next;
                size_code_reg  <= size_code_next;
                rate_code_reg  <= rate_code_next;
                chan_code_reg  <= chan_code_next;
                depth_code_reg <= depth_code_next;
                variable_reg   <= variable_next;
                number_reg     <= number_next;
                utf8_left_reg  <= utf8_left_next;
                opt_left_reg   <= opt_left_next;
                size_acc_reg   <= size_acc_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            in_item_reg <= hdr_byte;
        end
        if (fire && res_valid)
        begin
            out_item_reg <= out_item_next;
        end
    end

    // early verdicts carry no decoded size or number
    `FFHC_ASSERT_IMPLY(a_early_fields_zero,
        out_valid_reg && (out_item_reg.status != ST_VALID) &&
        (out_item_reg.status != ST_CRC) && (out_item_reg.status != ST_ZERO_SIZE),
        (out_item_reg.block_size == 17'd0) &&
        (out_item_reg.frame_or_sample_number == 36'd0),
        "early verdict carries decoded fields")

    // zero size status matches the reported size
    `FFHC_ASSERT_IMPLY(a_zero_size_match,
        out_valid_reg && ((out_item_reg.status == ST_VALID) ||
        (out_item_reg.status == ST_ZERO_SIZE)),
        (out_item_reg.block_size == 17'd0) == (out_item_reg.status == ST_ZERO_SIZE),
        "zero size status does not match block size")

    // a verdict closes the candidate
    `FFHC_ASSERT_NEXT(a_verdict_closes,
        fire && res_valid,
        !active_reg && out_valid_reg,
        "candidate still open after verdict")

    // byte counter saturates at the header limit
    `FFHC_ASSERT_IMPLY(a_pos_bound,
        1'b1,
        pos_reg <= BPOS_W'(MAX_HEADER_BYTES),
        "byte position beyond header limit")

endmodule
